@@ rtl/sfdp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdp_pkg
// shared types, constants and helpers of the font definition parser
// ----------------------------------------------------------------------------
package sfdp_pkg;

  localparam int unsigned MaxValues   = 6;
  localparam int unsigned NumberWidth = 16;
  localparam int unsigned FieldWidth  = 16;
  localparam int unsigned CountWidth  = $clog2(MaxValues + 1);
  localparam int unsigned IndexWidth  = $clog2(MaxValues);

  localparam logic [7:0] CharColon   = 8'h3a;
  localparam logic [7:0] CharComma   = 8'h2c;
  localparam logic [7:0] CharNewline = 8'h0a;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperZ  = 8'h5a;
  localparam logic [7:0] CaseOffset  = 8'h20;

  typedef logic [NumberWidth-1:0] number_t;
  typedef logic [FieldWidth-1:0]  field_t;
  typedef logic [CountWidth-1:0]  count_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SIZE    = 2'd1,
    KIND_TEXTURE = 2'd2,
    KIND_GLYPH   = 2'd3
  } line_kind_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] line_kind;
    logic       record_valid;
    field_t     glyph_code;
    field_t     first_value;
    field_t     second_value;
    field_t     third_value;
    field_t     fourth_value;
  } out_item_t;

  typedef struct packed {
    logic [2:0] len;
    logic       starts_digit;
    logic       digits_running;
    logic       size_match;
    logic       tex_match;
    number_t    acc;
  } token_t;

  localparam token_t TokenClear = '{
    len:            3'd0,
    starts_digit:   1'b0,
    digits_running: 1'b0,
    size_match:     1'b1,
    tex_match:      1'b1,
    acc:            '0
  };

  // lower-case keyword letters by position
  function automatic logic [7:0] size_char(logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h73; // s
      3'd1:    ch = 8'h69; // i
      3'd2:    ch = 8'h7a; // z
      3'd3:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] texture_char(logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h74; // t
      3'd1:    ch = 8'h65; // e
      3'd2:    ch = 8'h78; // x
      3'd3:    ch = 8'h74; // t
      3'd4:    ch = 8'h75; // u
      3'd5:    ch = 8'h72; // r
      3'd6:    ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // low bits of a number, zero extended when the number is narrower
  function automatic field_t to_field(number_t n);
    logic [NumberWidth+FieldWidth-1:0] w;
    w = {{FieldWidth{1'b0}}, n};
    return w[FieldWidth-1:0];
  endfunction

endpackage

@@ rtl/sprite_font_definition_parser.sv @@
// ----------------------------------------------------------------------------
// sprite_font_definition_parser
// byte stream parser for sprite font definition text, one record per line
// ----------------------------------------------------------------------------
// Takes one text byte per transfer and gives one record per text line (at a
// newline, or at the flagged last byte unless that byte is ':' or ','). A
// byte is taken every cycle unless the input register is stalled: each byte
// sits in the input register, is parsed in one pass of short logic and, if
// it closes a line, its record is loaded into the output register at the
// next edge, from where it is offered until taken. Bytes that close no line
// never wait on the output side; a byte that closes a line waits only while
// an earlier record is still held and not taken. Numbers saturate at all
// ones; up to six values are kept per line and at most the first four are
// reported. After the last byte all parser state returns to its reset value.
// ----------------------------------------------------------------------------
module sprite_font_definition_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfdp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfdp_pkg::out_item_t out_data_o
);

  // input register
  logic                in_valid_q;
  sfdp_pkg::in_item_t  in_data_q;
  // output register
  logic                out_valid_q;
  sfdp_pkg::out_item_t out_data_q;

  logic                in_xfer, out_free, proc_go, rec_hit;
  sfdp_pkg::out_item_t rec;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  // a held byte moves on unless its record would overwrite a pending one
  assign proc_go    = in_valid_q && (!rec_hit || out_free);
  assign in_ready_o = !in_valid_q || proc_go;

  sfdp_line u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (proc_go),
    .item_i    (in_data_q),
    .rec_hit_o (rec_hit),
    .rec_o     (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (proc_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go && rec_hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && rec_hit) begin
      out_data_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/sfdp_token.sv @@
// ----------------------------------------------------------------------------
// sfdp_token
// appends one byte to the current token: digit run, value, keyword prefixes
// ----------------------------------------------------------------------------
module sfdp_token (
  input  sfdp_pkg::token_t tok_i,
  input  logic [7:0]       byte_i,
  output sfdp_pkg::token_t tok_o
);

  localparam int unsigned AccWidth = sfdp_pkg::NumberWidth + 4;

  logic                             is_digit;
  logic [7:0]                       lower;
  logic [AccWidth-1:0]              acc_next;
  logic [7:0]                       digit_val;

  assign is_digit  = (byte_i >= sfdp_pkg::CharZero) && (byte_i <= sfdp_pkg::CharNine);
  assign lower     = ((byte_i >= sfdp_pkg::CharUpperA) && (byte_i <= sfdp_pkg::CharUpperZ)) ?
                     byte_i + sfdp_pkg::CaseOffset : byte_i;
  assign digit_val = byte_i - sfdp_pkg::CharZero;
  assign acc_next  = {4'b0, tok_i.acc} * AccWidth'(10) + AccWidth'(digit_val[3:0]);

  always_comb begin
    tok_o = tok_i;
    if (tok_i.len == 3'd0) begin
      tok_o.starts_digit   = is_digit;
      tok_o.digits_running = is_digit;
    end else if (!is_digit) begin
      tok_o.digits_running = 1'b0;
    end
    // saturate at all ones
    if (tok_o.digits_running) begin
      if (acc_next[AccWidth-1:sfdp_pkg::NumberWidth] != '0) begin
        tok_o.acc = '1;
      end else begin
        tok_o.acc = acc_next[sfdp_pkg::NumberWidth-1:0];
      end
    end
    if ((tok_i.len < 3'd4) && (lower != sfdp_pkg::size_char(tok_i.len))) begin
      tok_o.size_match = 1'b0;
    end
    if ((tok_i.len < 3'd7) && (lower != sfdp_pkg::texture_char(tok_i.len))) begin
      tok_o.tex_match = 1'b0;
    end
    if (tok_i.len < 3'd7) begin
      tok_o.len = tok_i.len + 3'd1;
    end
  end

endmodule

@@ rtl/sfdp_line.sv @@
// ----------------------------------------------------------------------------
// sfdp_line
// line state, value store and record assembly for one byte per cycle when stepped
// ----------------------------------------------------------------------------
module sfdp_line (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  sfdp_pkg::in_item_t   item_i,
  output logic                 rec_hit_o,
  output sfdp_pkg::out_item_t  rec_o
);

  sfdp_pkg::line_kind_e mode_q, mode_d;
  sfdp_pkg::token_t     tok_q, tok_d, tok_push, tok_end, tok_st;
  sfdp_pkg::number_t    held_q, held_d;
  sfdp_pkg::count_t     vc_q, vc_d, vc_after;
  sfdp_pkg::number_t    store_q [sfdp_pkg::MaxValues];
  sfdp_pkg::field_t     vals [4];

  logic [7:0] c;
  logic       fin, is_colon, is_comma, is_nl, wr_en, st_we;

  assign c        = item_i.text_byte;
  assign fin      = item_i.final_byte;
  assign is_colon = (c == sfdp_pkg::CharColon);
  assign is_comma = (c == sfdp_pkg::CharComma);
  assign is_nl    = (c == sfdp_pkg::CharNewline);

  sfdp_token u_token (
    .tok_i  (tok_q),
    .byte_i (c),
    .tok_o  (tok_push)
  );

  // a byte other than newline or comma joins the token before the store
  assign tok_end   = is_nl ? tok_q : tok_push;
  assign tok_st    = is_comma ? tok_q : tok_end;
  assign wr_en     = tok_st.starts_digit && (vc_q < sfdp_pkg::CountWidth'(sfdp_pkg::MaxValues));
  assign vc_after  = vc_q + sfdp_pkg::CountWidth'(wr_en);
  assign rec_hit_o = !is_colon && !is_comma && (is_nl || fin);

  // value read with bypass of the entry written by this byte
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (sfdp_pkg::CountWidth'(k) < vc_after) begin
        if (wr_en && (vc_q == sfdp_pkg::CountWidth'(k))) begin
          vals[k] = sfdp_pkg::to_field(tok_st.acc);
        end else begin
          vals[k] = sfdp_pkg::to_field(store_q[k]);
        end
      end else begin
        vals[k] = '0;
      end
    end
  end

  always_comb begin
    rec_o = '0;
    rec_o.line_kind = mode_q;
    unique case (mode_q)
      sfdp_pkg::KIND_SIZE: begin
        rec_o.record_valid = (vc_after >= sfdp_pkg::CountWidth'(2));
        rec_o.first_value  = vals[0];
        rec_o.second_value = vals[1];
      end
      sfdp_pkg::KIND_TEXTURE: begin
        rec_o.record_valid = 1'b1;
      end
      sfdp_pkg::KIND_GLYPH: begin
        rec_o.record_valid = (vc_after >= sfdp_pkg::CountWidth'(4));
        rec_o.glyph_code   = sfdp_pkg::to_field(held_q);
        rec_o.first_value  = vals[0];
        rec_o.second_value = vals[1];
        rec_o.third_value  = vals[2];
        rec_o.fourth_value = vals[3];
      end
      default: begin
        rec_o.record_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    tok_d  = tok_q;
    held_d = held_q;
    vc_d   = vc_q;
    st_we  = 1'b0;
    priority if (is_colon) begin
      priority if (tok_q.starts_digit) begin
        held_d = tok_q.acc;
        mode_d = sfdp_pkg::KIND_GLYPH;
        vc_d   = '0;
        tok_d  = sfdp_pkg::TokenClear;
      end else if ((tok_q.len >= 3'd4) && tok_q.size_match) begin
        mode_d = sfdp_pkg::KIND_SIZE;
        vc_d   = '0;
        tok_d  = sfdp_pkg::TokenClear;
      end else if ((tok_q.len == 3'd7) && tok_q.tex_match) begin
        mode_d = sfdp_pkg::KIND_TEXTURE;
        tok_d  = sfdp_pkg::TokenClear;
      end else begin
        tok_d = tok_push;
      end
    end else if (is_comma) begin
      st_we = wr_en;
      vc_d  = vc_after;
      tok_d = sfdp_pkg::TokenClear;
    end else if (rec_hit_o) begin
      st_we  = wr_en;
      vc_d   = vc_after;
      mode_d = sfdp_pkg::KIND_NONE;
      tok_d  = sfdp_pkg::TokenClear;
    end else begin
      tok_d = tok_push;
    end
    // end of text: back to the reset state
    if (fin) begin
      mode_d = sfdp_pkg::KIND_NONE;
      tok_d  = sfdp_pkg::TokenClear;
      held_d = '0;
      vc_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sfdp_pkg::KIND_NONE;
      tok_q  <= sfdp_pkg::TokenClear;
      held_q <= '0;
      vc_q   <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      tok_q  <= tok_d;
      held_q <= held_d;
      vc_q   <= vc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && st_we) begin
      store_q[vc_q[sfdp_pkg::IndexWidth-1:0]] <= tok_st.acc;
    end
  end

endmodule
